/* hw/rtl/apu_pkg.sv */
// apu_pkg: widths, constants and the pipeline stage word of the alpha unpremultiply unit
// no dependencies; imported by the interfaces and the top level
package apu_pkg;

    localparam int CHAN_W   = 8;              // bits per color or alpha byte
    localparam int NUM_W    = 2 * CHAN_W;     // c*255 + alpha/2 fits in 16 bits
    localparam int N_CHAN   = 3;              // blue, green, red
    localparam int N_DIV    = 4;              // division stages, two quotient bits each
    localparam int N_STG    = N_DIV + 1;      // numerator stage plus division stages

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_ZERO = 8'd0;

    // channel slots inside a stage word
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [NUM_W-1:0]  t_num;

    typedef struct packed {
        logic [N_CHAN-1:0][NUM_W-1:0]  rem;     // partial remainder
        logic [N_CHAN-1:0][CHAN_W-1:0] quo;     // quotient bits so far
        logic [N_CHAN-1:0][CHAN_W-1:0] raw;     // original channel for pass-through
        logic [N_CHAN-1:0]             sat;     // quotient would exceed 255
        logic [CHAN_W-1:0]             alpha;
        logic                          bypass;  // alpha is 0 or 255
    } t_stage;

endpackage

/* hw/rtl/apu_in_if.sv */
// apu_in_if: valid/ready channel carrying one premultiplied bgra word
// depends on apu_pkg
interface apu_in_if
    import apu_pkg::*;
();
    logic  valid;
    logic  ready;
    t_chan blue_in;
    t_chan green_in;
    t_chan red_in;
    t_chan alpha_in;

    modport source (output valid, blue_in, green_in, red_in, alpha_in, input ready);
    modport sink   (input valid, blue_in, green_in, red_in, alpha_in, output ready);
endinterface

/* hw/rtl/apu_out_if.sv */
// apu_out_if: valid/ready channel carrying one straight-alpha bgra word
// depends on apu_pkg
interface apu_out_if
    import apu_pkg::*;
();
    logic  valid;
    logic  ready;
    t_chan blue_out;
    t_chan green_out;
    t_chan red_out;
    t_chan alpha_out;

    modport source (output valid, blue_out, green_out, red_out, alpha_out, input ready);
    modport sink   (input valid, blue_out, green_out, red_out, alpha_out, output ready);
endinterface

/* hw/rtl/alpha_unpremultiply_pixel_unit.sv */
// alpha_unpremultiply_pixel_unit: five register stages, one word accepted per cycle while the entry stage has room
// an accepted word enters the numerator stage, then moves through the division stages in order to o_pix
// throughput: one word per cycle unless the output stalls; the restoring divider resolves two bits per stage
// stalls hold words in place; empty stages fill even while the output waits
// reset: synchronous active-low i_rst_n clears all stage valid bits
// depends on apu_pkg, apu_in_if, apu_out_if
module alpha_unpremultiply_pixel_unit
    import apu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    apu_in_if.sink    i_pix,
    apu_out_if.source o_pix
);

    // one restoring division step on all three channels: try alpha shifted to bit b
    function automatic t_stage div_step(t_stage st, logic [2:0] b);
        t_stage res;
        t_num   dsr;
        res = st;
        dsr = t_num'(st.alpha) << b;
        for (int ch = 0; ch < N_CHAN; ch++) begin
            if (st.rem[ch] >= dsr) begin
                res.rem[ch]    = st.rem[ch] - dsr;
                res.quo[ch][b] = 1'b1;
            end
        end
        return res;
    endfunction

    // stage registers: index 0 holds the numerator, 1..N_DIV run the division
    t_stage           r_stg [N_STG];
    logic [N_STG-1:0] r_vld;
    t_stage           n_stg [N_STG];
    logic [N_STG-1:0] stg_en;

    // a stage may load when it is empty or its word moves on this cycle
    always_comb begin
        stg_en[N_STG-1] = !r_vld[N_STG-1] || o_pix.ready;
        for (int s = N_STG - 2; s >= 0; s--) begin
            stg_en[s] = !r_vld[s] || stg_en[s+1];
        end
    end

    assign i_pix.ready = stg_en[0];

    // numerator stage: n = c*255 + alpha/2, and the saturation test n >= 256*alpha
    always_comb begin
        t_chan  c [N_CHAN];
        t_num   num;
        t_num   lim;
        c[CH_BLUE]  = i_pix.blue_in;
        c[CH_GREEN] = i_pix.green_in;
        c[CH_RED]   = i_pix.red_in;
        lim = {i_pix.alpha_in, ALPHA_ZERO};
        n_stg[0].alpha  = i_pix.alpha_in;
        n_stg[0].bypass = (i_pix.alpha_in == ALPHA_ZERO) || (i_pix.alpha_in == CHAN_MAX);
        for (int ch = 0; ch < N_CHAN; ch++) begin
            // c*255 as c*256 - c, never negative
            num = ({c[ch], ALPHA_ZERO} - t_num'(c[ch])) + t_num'(i_pix.alpha_in[CHAN_W-1:1]);
            n_stg[0].rem[ch] = num;
            n_stg[0].quo[ch] = '0;
            n_stg[0].raw[ch] = c[ch];
            // past this point the quotient cannot fit in a byte
            n_stg[0].sat[ch] = (num >= lim);
        end
    end

    // division stages, quotient bits resolved msb first, two per stage
    for (genvar s = 1; s < N_STG; s++) begin : g_div
        localparam int HI = 2 * (N_DIV - s) + 1;
        always_comb begin
            n_stg[s] = div_step(div_step(r_stg[s-1], 3'(HI)), 3'(HI - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < N_STG; s++) begin
                if (stg_en[s]) begin
                    r_vld[s] <= (s == 0) ? i_pix.valid : r_vld[(s == 0) ? 0 : s - 1];
                end
            end
        end
    end

    // payload carries no reset
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < N_STG; s++) begin
            if (stg_en[s]) begin
                r_stg[s] <= n_stg[s];
            end
        end
    end

    // final select: pass-through, saturate or quotient
    t_chan w_chan_out [N_CHAN];

    always_comb begin
        for (int ch = 0; ch < N_CHAN; ch++) begin
            priority if (r_stg[N_STG-1].bypass) begin
                w_chan_out[ch] = r_stg[N_STG-1].raw[ch];
            end else if (r_stg[N_STG-1].sat[ch]) begin
                w_chan_out[ch] = CHAN_MAX;
            end else begin
                w_chan_out[ch] = r_stg[N_STG-1].quo[ch];
            end
        end
    end

    assign o_pix.valid     = r_vld[N_STG-1];
    assign o_pix.blue_out  = w_chan_out[CH_BLUE];
    assign o_pix.green_out = w_chan_out[CH_GREEN];
    assign o_pix.red_out   = w_chan_out[CH_RED];
    assign o_pix.alpha_out = r_stg[N_STG-1].alpha;

    // remainder left by the divider must be below alpha when the quotient is used
    logic w_rem_ok;

    always_comb begin
        w_rem_ok = 1'b1;
        for (int ch = 0; ch < N_CHAN; ch++) begin
            if (!r_stg[N_STG-1].sat[ch] &&
                r_stg[N_STG-1].rem[ch] >= t_num'(r_stg[N_STG-1].alpha)) begin
                w_rem_ok = 1'b0;
            end
        end
    end

    // an empty entry stage always takes a word
    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> i_pix.ready)
        else $error("input stalled with an empty entry stage");

    // an accepted word lands in the entry stage with its alpha
    a_entry_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> (r_vld[0] && r_stg[0].alpha == $past(i_pix.alpha_in)))
        else $error("accepted word not captured in entry stage");

    // divider finished with a proper remainder on every non-saturated channel
    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[N_STG-1] && !r_stg[N_STG-1].bypass) |-> w_rem_ok)
        else $error("divider remainder not below alpha");

endmodule
